// ----- rtl/mag_pkg.sv -----
// Shared types and address constants of the memory access guard.
package mag_pkg;

    // Command codes carried by i_cmd.
    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_ADD_WATCH = 2'd2;

    // Address map boundaries (half-open ranges, low bound inclusive).
    localparam logic [17:0] A_HOLE_A_LO  = 18'h0fefc;
    localparam logic [17:0] A_HOLE_A_HI  = 18'h0ff00;
    localparam logic [17:0] A_HOLE_B_LO  = 18'h0ff34;
    localparam logic [17:0] A_HOLE_B_HI  = 18'h0ff40;
    localparam logic [17:0] A_AUDIO_LO   = 18'h0ff40;
    localparam logic [17:0] A_AUDIO_HI   = 18'h0ff70;
    localparam logic [17:0] A_IO_LO      = 18'h0ff70;
    localparam logic [17:0] A_IO_STATUS  = 18'h0ff87;
    localparam logic [17:0] A_WR_HOLE_LO = 18'h0ff88;
    localparam logic [17:0] A_RD_HOLE_LO = 18'h0ff8c;
    localparam logic [17:0] A_IO_HI      = 18'h0ffa0;
    localparam logic [17:0] A_CTR_LO     = 18'h0ffa6;
    localparam logic [17:0] A_TOP_LO     = 18'h0ffb0;
    localparam logic [17:0] A_ROM_LO     = 18'h10000;
    localparam logic [17:0] A_PRAM_LO    = 18'h0e000;
    localparam logic [17:0] A_PRAM_HI    = 18'h0fb00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } t_dp_status;

endpackage

// ----- rtl/memory_access_guard_with_watchpoints.sv -----
// Top level of the memory access guard: controller, datapath and checks.
//
// The block checks each bus transaction (read, write or add-watchpoint)
// against the console's address map and its watchpoint table.
// A transaction is taken at a rising edge where start is high and busy is
// low; the command, address, watch flags and pause flag are latched then.
// Busy stays high until the result is ready. The result appears on the o_
// result ports for exactly one cycle, marked by o_valid, and is taken at the
// edge that ends that cycle; the receiver cannot stall, so no result waits.
// Busy is already low during the o_valid cycle, so a new transaction can be
// started in that same cycle.
// Sequence: a decode step, then a walk over the watchpoint table, then a
// state update step. The walk is skipped when it is not needed (illegal
// access, counter byte, paused read or write, empty table, unused command);
// otherwise it stops at the first matching entry, or after all stored
// entries when nothing matches. The walk reads one table entry per cycle
// through the single read port of the table memory.
// Synchronous reset empties the table and clears the persistent RAM and
// audio flags; no clearing pass is needed, since only filled entries are read.
module memory_access_guard_with_watchpoints #(
    parameter int MAX_WATCH = 16,
    parameter int MAP_LAST  = 131071
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [17:0] i_address,
    input  logic        i_watch_read,
    input  logic        i_watch_write,
    input  logic        i_paused,
    output logic        o_valid,
    output logic        o_allowed,
    output logic [3:0]  o_counter_byte,
    output logic        o_persistent_load,
    output logic        o_persistent_dirty,
    output logic        o_watch_hit,
    output logic        o_audio_turned_on,
    output logic        o_watch_dropped
);
    import mag_pkg::*;

    t_ctrl_cmd  ctrl;
    t_dp_status status;

    // The controller sequences decode, table walk and state update.
    mag_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_ctrl   (ctrl),
        .i_status (status)
    );

    // The datapath holds the watchpoint table, the sticky flags and the results.
    mag_dpath #(
        .MAX_WATCH (MAX_WATCH),
        .MAP_LAST  (MAP_LAST)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .o_status           (status),
        .i_cmd              (i_cmd),
        .i_address          (i_address),
        .i_watch_read       (i_watch_read),
        .i_watch_write      (i_watch_write),
        .i_paused           (i_paused),
        .o_allowed          (o_allowed),
        .o_counter_byte     (o_counter_byte),
        .o_persistent_load  (o_persistent_load),
        .o_persistent_dirty (o_persistent_dirty),
        .o_watch_hit        (o_watch_hit),
        .o_audio_turned_on  (o_audio_turned_on),
        .o_watch_dropped    (o_watch_dropped)
    );

    // A result is only shown once the block has finished its transaction.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without going busy");

    // Counter-byte reads are legal and never checked against watchpoints.
    a_counter_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_counter_byte != 4'd0) |-> (o_allowed && !o_watch_hit))
        else $error("counter byte result inconsistent");

    // A dropped watchpoint request is never combined with an access flag.
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_watch_dropped) |->
            (o_allowed && !o_watch_hit && !o_persistent_load && !o_audio_turned_on))
        else $error("dropped watchpoint with access flags");

endmodule

// ----- rtl/mag_ctrl.sv -----
// Controller state machine of the memory access guard.
module mag_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    output logic                  o_valid,
    output mag_pkg::t_ctrl_cmd    o_ctrl,
    input  mag_pkg::t_dp_status   i_status
);
    import mag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_status.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FINISH);
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_ctrl.load   = (r_state == S_IDLE) && i_start;
    assign o_ctrl.scan   = (r_state == S_SCAN);
    assign o_ctrl.finish = (r_state == S_FINISH);

endmodule

// ----- rtl/mag_dpath.sv -----
// Datapath of the memory access guard: address decode, watchpoint table and flags.
module mag_dpath #(
    parameter int MAX_WATCH = 16,
    parameter int MAP_LAST  = 131071
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mag_pkg::t_ctrl_cmd    i_ctrl,
    output mag_pkg::t_dp_status   o_status,
    input  logic [1:0]            i_cmd,
    input  logic [17:0]           i_address,
    input  logic                  i_watch_read,
    input  logic                  i_watch_write,
    input  logic                  i_paused,
    output logic                  o_allowed,
    output logic [3:0]            o_counter_byte,
    output logic                  o_persistent_load,
    output logic                  o_persistent_dirty,
    output logic                  o_watch_hit,
    output logic                  o_audio_turned_on,
    output logic                  o_watch_dropped
);
    import mag_pkg::*;

    localparam int CNT_W = $clog2(MAX_WATCH + 1);
    localparam int IDX_W = (MAX_WATCH > 1) ? $clog2(MAX_WATCH) : 1;
    localparam logic [CNT_W-1:0] DEPTH      = CNT_W'(MAX_WATCH);
    localparam logic [17:0]      MAP_LAST_A = 18'(MAP_LAST);

    typedef struct packed {
        logic [15:0] addr;
        logic        on_rd;
        logic        on_wr;
    } t_watch_entry;

    t_watch_entry r_mem [MAX_WATCH];

    // Latched transaction.
    logic [1:0]  r_cmd;
    logic [17:0] r_addr;
    logic        r_wrd, r_wwr, r_paused;

    // Scan state.
    logic [CNT_W-1:0] r_ptr;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    t_watch_entry     r_rdata;
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_hit_rd, r_hit_wr;

    // Persistent state.
    logic [CNT_W-1:0] r_count;
    logic             r_seen, r_written, r_audio_on;

    // Result registers.
    logic       r_allowed, r_load, r_dirty, r_hit, r_audio, r_dropped;
    logic [3:0] r_counter;

    logic is_rd, is_wr, is_add;
    logic rd_bad, wr_bad, rd_ok, wr_ok;
    logic ctr_rng, pram_rng, audio_rng;
    logic issue, cmp_eq, touch, append;
    logic we;
    logic [IDX_W-1:0] widx;
    t_watch_entry     wdata;
    logic       n_allowed, n_load, n_written, n_hit, n_audio, n_dropped;
    logic [3:0] n_counter;

    // Address decode of the latched transaction.
    always_comb begin
        is_rd  = (r_cmd == CMD_READ);
        is_wr  = (r_cmd == CMD_WRITE);
        is_add = (r_cmd == CMD_ADD_WATCH);

        rd_bad = (r_addr > MAP_LAST_A)
              || (r_addr >= A_HOLE_A_LO  && r_addr < A_HOLE_A_HI)
              || (r_addr >= A_HOLE_B_LO  && r_addr < A_HOLE_B_HI)
              || (r_addr >= A_RD_HOLE_LO && r_addr < A_IO_HI)
              || (r_addr >= A_TOP_LO     && r_addr < A_ROM_LO);
        wr_bad = (r_addr >= A_ROM_LO)
              || (r_addr >= A_HOLE_A_LO  && r_addr < A_HOLE_A_HI)
              || (r_addr >= A_HOLE_B_LO  && r_addr < A_HOLE_B_HI)
              || (r_addr >= A_WR_HOLE_LO && r_addr < A_ROM_LO)
              || (r_addr >= A_IO_LO && r_addr < A_IO_HI && r_addr != A_IO_STATUS);

        ctr_rng   = (r_addr >= A_CTR_LO   && r_addr < A_TOP_LO);
        pram_rng  = (r_addr >= A_PRAM_LO  && r_addr < A_PRAM_HI);
        audio_rng = (r_addr >= A_AUDIO_LO && r_addr < A_AUDIO_HI);

        rd_ok = is_rd && !rd_bad;
        wr_ok = is_wr && !wr_bad;
    end

    // Table walk: one read issued per cycle, compared the cycle after.
    assign issue  = (r_ptr < r_count);
    assign cmp_eq = r_cmp_vld && (r_rdata.addr == r_addr[15:0]);

    assign o_status.need_scan = (r_count != '0)
        && (is_add || ((((rd_ok && !ctr_rng) || wr_ok)) && !r_paused));
    assign o_status.scan_done = cmp_eq || (!r_cmp_vld && (r_ptr != '0));

    // Outcome of the transaction.
    always_comb begin
        touch     = pram_rng && ((rd_ok && !ctr_rng) || wr_ok);
        append    = is_add && !r_found && (r_count < DEPTH);
        n_allowed = rd_ok || wr_ok || is_add;
        n_counter = (rd_ok && ctr_rng) ? 4'(r_addr - (A_CTR_LO - 18'd1)) : 4'd0;
        n_load    = touch && !r_seen;
        n_written = r_written || (wr_ok && pram_rng);
        n_hit     = r_found && ((rd_ok && r_hit_rd) || (wr_ok && r_hit_wr));
        n_audio   = wr_ok && audio_rng && !r_audio_on;
        n_dropped = is_add && !r_found && (r_count >= DEPTH);

        we          = i_ctrl.finish && is_add && (r_found || append);
        widx        = r_found ? r_hit_idx : r_count[IDX_W-1:0];
        wdata.addr  = r_addr[15:0];
        wdata.on_rd = r_wrd || (r_found && r_hit_rd);
        wdata.on_wr = r_wwr || (r_found && r_hit_wr);
    end

    // Watchpoint table.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[widx] <= wdata;
        end
        if (i_ctrl.scan && issue) begin
            r_rdata <= r_mem[r_ptr[IDX_W-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_count    <= '0;
            r_seen     <= 1'b0;
            r_written  <= 1'b0;
            r_audio_on <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (i_ctrl.scan) begin
                if (issue) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                r_cmp_vld <= issue;
                if (cmp_eq) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctrl.finish) begin
                r_seen     <= r_seen || touch;
                r_written  <= n_written;
                r_audio_on <= r_audio_on || n_audio;
                if (append) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_cmd;
            r_addr   <= i_address;
            r_wrd    <= i_watch_read;
            r_wwr    <= i_watch_write;
            r_paused <= i_paused;
        end
        if (i_ctrl.scan) begin
            r_cmp_idx <= r_ptr[IDX_W-1:0];
            if (cmp_eq) begin
                r_hit_idx <= r_cmp_idx;
                r_hit_rd  <= r_rdata.on_rd;
                r_hit_wr  <= r_rdata.on_wr;
            end
        end
        if (i_ctrl.finish) begin
            r_allowed <= n_allowed;
            r_counter <= n_counter;
            r_load    <= n_load;
            r_dirty   <= n_written;
            r_hit     <= n_hit;
            r_audio   <= n_audio;
            r_dropped <= n_dropped;
        end
    end

    assign o_allowed          = r_allowed;
    assign o_counter_byte     = r_counter;
    assign o_persistent_load  = r_load;
    assign o_persistent_dirty = r_dirty;
    assign o_watch_hit        = r_hit;
    assign o_audio_turned_on  = r_audio;
    assign o_watch_dropped    = r_dropped;

endmodule
